FILE: hdl/srp_pkg.sv
package srp_pkg;

	// input kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// protocol constants
	localparam logic [7:0] VERSION_5   = 8'h05;
	localparam logic [7:0] CMD_MIN     = 8'h01;
	localparam logic [7:0] CMD_MAX     = 8'h03;
	localparam logic [7:0] RSV_VALUE   = 8'h00;
	localparam logic [7:0] ATYP_IPV4   = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN = 8'h03;
	localparam logic [7:0] ATYP_IPV6   = 8'h04;
	localparam logic [7:0] IPV4_LEN    = 8'd4;
	localparam logic [7:0] IPV6_LEN    = 8'd16;
	localparam logic [7:0] MAX_INDEX   = 8'd255;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;

	// parser phases, numbered in field order
	typedef enum logic [3:0] {
		PH_VERSION = 4'd0,
		PH_CMD     = 4'd1,
		PH_RSV     = 4'd2,
		PH_ATYP    = 4'd3,
		PH_IPV4    = 4'd4,
		PH_IPV6    = 4'd5,
		PH_DLEN    = 4'd6,
		PH_DOMAIN  = 4'd7,
		PH_PORT    = 4'd8,
		PH_DONE    = 4'd9,
		PH_ERROR   = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic        consumed;
		status_t     status;
		phase_t      phase;
		logic [1:0]  command;
		logic [7:0]  address_type;
		logic        addr_valid;
		logic [7:0]  addr_byte;
		logic [7:0]  addr_index;
		logic [7:0]  domain_length;
		logic [15:0] dst_port;
	} rsp_t;

endpackage

FILE: hdl/srp_req_if.sv
interface srp_req_if;
	logic          valid;
	logic          ready;
	srp_pkg::req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hdl/srp_rsp_if.sv
interface srp_rsp_if;
	logic          valid;
	logic          ready;
	srp_pkg::rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hdl/socks5_request_parser_top.sv
// SOCKS5 request parser.
// req channel: one request byte per request (kind = data) or a restart
//   (kind = restart) that returns the parser to the version phase.
// rsp channel: exactly one result per request: consumed flag, status,
//   phase, command, address type, the address byte with its index when
//   the byte belonged to the destination address, domain length and port.
// Registers: one input register, then one result register; a request's
//   result is loaded into the result register when the pipeline advances.
// Throughput: one request per cycle unless rsp stalls; the phase update
//   is a single level of decode between the input and result registers.
// Reset (arst_n low) clears the valid bits of both register stages and
//   returns the parser to the version phase with all fields zero.
// When rsp is stalled the result register holds; the input register still
//   takes one more request, after which req.ready drops until rsp moves.
module socks5_request_parser_top (
	input logic      clk,
	input logic      arst_n,
	srp_req_if.sink  req,
	srp_rsp_if.source rsp
);

	logic          vld_s1;
	srp_pkg::req_t req_s1;
	logic          vld_s2;
	srp_pkg::rsp_t rsp_s2;
	srp_pkg::rsp_t rsp_d;
	logic          advance;

	// pipeline moves when the result register is free or being drained
	assign advance   = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || advance;

	srp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req.ready)
				vld_s1 <= req.valid;
			if (advance)
				vld_s2 <= 1'b1;
			else if (rsp.ready)
				vld_s2 <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			req_s1 <= req.payload;
		if (advance)
			rsp_s2 <= rsp_d;
	end

	assign rsp.valid   = vld_s2;
	assign rsp.payload = rsp_s2;

`ifndef SYNTHESIS
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vld_s2)
		else $error("result register not loaded after advance");

	a_restart_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.kind == srp_pkg::KIND_RESTART) |=>
		(rsp_s2.phase == srp_pkg::PH_VERSION && !rsp_s2.consumed))
		else $error("restart did not return parser to version phase");

	a_addr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && rsp_s2.addr_valid) |->
		(rsp_s2.phase == srp_pkg::PH_IPV4 || rsp_s2.phase == srp_pkg::PH_IPV6 ||
		 rsp_s2.phase == srp_pkg::PH_DOMAIN || rsp_s2.phase == srp_pkg::PH_PORT))
		else $error("address byte flagged outside address phases");

	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && rsp_s2.status == srp_pkg::ST_DONE) |->
		(rsp_s2.phase == srp_pkg::PH_DONE && rsp_s2.command != 2'd0))
		else $error("complete status without done phase and command");
`endif

endmodule

FILE: hdl/srp_core.sv
module srp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  srp_pkg::req_t req,
	output srp_pkg::rsp_t rsp
);

	srp_pkg::phase_t phase_q, phase_d;
	logic [1:0]  cmd_q, cmd_d;
	logic [7:0]  atyp_q, atyp_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  dlen_q, dlen_d;
	logic [15:0] port_q, port_d;
	logic        half_q, half_d;

	logic        consumed;
	logic        addr_valid;
	logic [7:0]  addr_byte;
	logic [7:0]  addr_index;
	logic [7:0]  cnt_inc;
	logic [7:0]  b;

	assign b       = req.data_byte;
	assign cnt_inc = cnt_q + 8'd1;

	// next state for one request byte
	always_comb begin
		phase_d    = phase_q;
		cmd_d      = cmd_q;
		atyp_d     = atyp_q;
		cnt_d      = cnt_q;
		dlen_d     = dlen_q;
		port_d     = port_q;
		half_d     = half_q;
		consumed   = 1'b0;
		addr_valid = 1'b0;
		addr_byte  = srp_pkg::ZERO_BYTE;
		addr_index = srp_pkg::ZERO_BYTE;
		if (req.kind == srp_pkg::KIND_RESTART) begin
			phase_d = srp_pkg::PH_VERSION;
			cmd_d   = 2'd0;
			atyp_d  = srp_pkg::ZERO_BYTE;
			cnt_d   = srp_pkg::ZERO_BYTE;
			dlen_d  = srp_pkg::ZERO_BYTE;
			port_d  = 16'd0;
			half_d  = 1'b0;
		end else if (phase_q != srp_pkg::PH_DONE && phase_q != srp_pkg::PH_ERROR) begin
			consumed = 1'b1;
			unique case (phase_q)
				srp_pkg::PH_VERSION: begin
					phase_d = (b == srp_pkg::VERSION_5) ? srp_pkg::PH_CMD : srp_pkg::PH_ERROR;
				end
				srp_pkg::PH_CMD: begin
					if (b >= srp_pkg::CMD_MIN && b <= srp_pkg::CMD_MAX) begin
						cmd_d   = b[1:0];
						phase_d = srp_pkg::PH_RSV;
					end else begin
						phase_d = srp_pkg::PH_ERROR;
					end
				end
				srp_pkg::PH_RSV: begin
					// a bad reserved byte is left in the stream
					if (b != srp_pkg::RSV_VALUE) begin
						consumed = 1'b0;
						phase_d  = srp_pkg::PH_ERROR;
					end else begin
						phase_d = srp_pkg::PH_ATYP;
					end
				end
				srp_pkg::PH_ATYP: begin
					atyp_d = b;
					cnt_d  = srp_pkg::ZERO_BYTE;
					if (b == srp_pkg::ATYP_IPV4)
						phase_d = srp_pkg::PH_IPV4;
					else if (b == srp_pkg::ATYP_IPV6)
						phase_d = srp_pkg::PH_IPV6;
					else if (b == srp_pkg::ATYP_DOMAIN)
						phase_d = srp_pkg::PH_DLEN;
					else
						phase_d = srp_pkg::PH_ERROR;
				end
				srp_pkg::PH_IPV4: begin
					addr_valid = 1'b1;
					addr_byte  = b;
					addr_index = cnt_q;
					cnt_d      = cnt_inc;
					if (cnt_inc >= srp_pkg::IPV4_LEN) begin
						half_d  = 1'b0;
						phase_d = srp_pkg::PH_PORT;
					end
				end
				srp_pkg::PH_IPV6: begin
					addr_valid = 1'b1;
					addr_byte  = b;
					addr_index = cnt_q;
					cnt_d      = cnt_inc;
					if (cnt_inc >= srp_pkg::IPV6_LEN) begin
						half_d  = 1'b0;
						phase_d = srp_pkg::PH_PORT;
					end
				end
				srp_pkg::PH_DLEN: begin
					dlen_d = b;
					if (b == srp_pkg::ZERO_BYTE) begin
						phase_d = srp_pkg::PH_ERROR;
					end else begin
						cnt_d   = srp_pkg::ZERO_BYTE;
						phase_d = srp_pkg::PH_DOMAIN;
					end
				end
				srp_pkg::PH_DOMAIN: begin
					if (cnt_q < dlen_q && cnt_q < srp_pkg::MAX_INDEX) begin
						addr_valid = 1'b1;
						addr_byte  = b;
						addr_index = cnt_q;
						cnt_d      = cnt_inc;
						if (cnt_inc >= dlen_q) begin
							half_d  = 1'b0;
							phase_d = srp_pkg::PH_PORT;
						end
					end else begin
						consumed = 1'b0;
						phase_d  = srp_pkg::PH_ERROR;
					end
				end
				srp_pkg::PH_PORT: begin
					// high byte first
					if (!half_q) begin
						port_d = {b, 8'h00};
						half_d = 1'b1;
					end else begin
						port_d  = {port_q[15:8], port_q[7:0] | b};
						phase_d = srp_pkg::PH_DONE;
					end
				end
				default: begin
					consumed = 1'b0;
					phase_d  = srp_pkg::PH_ERROR;
				end
			endcase
		end
	end

	// result built from the updated state
	always_comb begin
		rsp.consumed      = consumed;
		rsp.status        = (phase_d == srp_pkg::PH_DONE)  ? srp_pkg::ST_DONE :
		                    (phase_d == srp_pkg::PH_ERROR) ? srp_pkg::ST_ERROR :
		                                                     srp_pkg::ST_BUSY;
		rsp.phase         = phase_d;
		rsp.command       = cmd_d;
		rsp.address_type  = atyp_d;
		rsp.addr_valid    = addr_valid;
		rsp.addr_byte     = addr_byte;
		rsp.addr_index    = addr_index;
		rsp.domain_length = (atyp_d == srp_pkg::ATYP_DOMAIN) ? dlen_d : srp_pkg::ZERO_BYTE;
		rsp.dst_port      = port_d;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srp_pkg::PH_VERSION;
			cmd_q   <= 2'd0;
			atyp_q  <= srp_pkg::ZERO_BYTE;
			cnt_q   <= srp_pkg::ZERO_BYTE;
			dlen_q  <= srp_pkg::ZERO_BYTE;
			port_q  <= 16'd0;
			half_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			atyp_q  <= atyp_d;
			cnt_q   <= cnt_d;
			dlen_q  <= dlen_d;
			port_q  <= port_d;
			half_q  <= half_d;
		end
	end

endmodule
